// ===== sv/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-key scanner package
// Shared types and reset constants for the two-key debounce and click block.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int unsigned TIMER_W = 16;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned INDEX_W = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_CAL_ENABLE      = 3'd0,
    REG_DEBOUNCE_TIME   = 3'd1,
    REG_LONG_PRESS_TIME = 3'd2,
    REG_REPEAT_PERIOD   = 3'd3,
    REG_BOTH_LONG_TIME  = 3'd4,
    REG_CLICK_WINDOW    = 3'd5,
    REG_HOLD_START_TIME = 3'd6
  } reg_index_t;

  localparam logic [TIMER_W-1:0] RST_DEBOUNCE_TIME   = 16'd20;
  localparam logic [TIMER_W-1:0] RST_LONG_PRESS_TIME = 16'd3000;
  localparam logic [TIMER_W-1:0] RST_REPEAT_PERIOD   = 16'd100;
  localparam logic [TIMER_W-1:0] RST_BOTH_LONG_TIME  = 16'd2000;
  localparam logic [TIMER_W-1:0] RST_CLICK_WINDOW    = 16'd600;
  localparam logic [TIMER_W-1:0] RST_HOLD_START_TIME = 16'd800;

  typedef struct packed {
    logic               cal_enable;
    logic [TIMER_W-1:0] debounce_time;
    logic [TIMER_W-1:0] long_press_time;
    logic [TIMER_W-1:0] repeat_period;
    logic [TIMER_W-1:0] both_long_time;
    logic [TIMER_W-1:0] click_window;
    logic [TIMER_W-1:0] hold_start_time;
  } cfg_t;

  typedef struct packed {
    logic               power_short;
    logic               power_long;
    logic               power_repeat;
    logic               mode_single;
    logic               mode_repeat;
    logic               mode_clicks;
    logic [COUNT_W-1:0] click_total;
    logic               both_long;
    logic               power_down;
    logic               mode_down;
  } result_t;

endpackage

// ===== sv/tkd_cfg.sv =====
// ----------------------------------------------------------------------------
// Two-key scanner configuration registers
// Holds the mode and timing registers and flags a write of the mode register.
// ----------------------------------------------------------------------------
module tkd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [tkd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [tkd_pkg::TIMER_W-1:0] cfg_data,
  output tkd_pkg::cfg_t               cfg,
  output logic                        mode_clear
);

  assign mode_clear = cfg_write && (cfg_index == tkd_pkg::REG_CAL_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_enable      <= 1'b0;
      cfg.debounce_time   <= tkd_pkg::RST_DEBOUNCE_TIME;
      cfg.long_press_time <= tkd_pkg::RST_LONG_PRESS_TIME;
      cfg.repeat_period   <= tkd_pkg::RST_REPEAT_PERIOD;
      cfg.both_long_time  <= tkd_pkg::RST_BOTH_LONG_TIME;
      cfg.click_window    <= tkd_pkg::RST_CLICK_WINDOW;
      cfg.hold_start_time <= tkd_pkg::RST_HOLD_START_TIME;
    end else if (cfg_write) begin
      case (cfg_index)
        tkd_pkg::REG_CAL_ENABLE:      cfg.cal_enable      <= cfg_data[0];
        tkd_pkg::REG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_data;
        tkd_pkg::REG_LONG_PRESS_TIME: cfg.long_press_time <= cfg_data;
        tkd_pkg::REG_REPEAT_PERIOD:   cfg.repeat_period   <= cfg_data;
        tkd_pkg::REG_BOTH_LONG_TIME:  cfg.both_long_time  <= cfg_data;
        tkd_pkg::REG_CLICK_WINDOW:    cfg.click_window    <= cfg_data;
        tkd_pkg::REG_HOLD_START_TIME: cfg.hold_start_time <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/tkd_core.sv =====
// ----------------------------------------------------------------------------
// Two-key scanner event core
// Holds key and click state and computes one tick's result from the inputs.
// ----------------------------------------------------------------------------
module tkd_core #(
  parameter int unsigned TICK_MS    = 10,
  parameter int unsigned MAX_CLICKS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             power_raw,
  input  logic             mode_raw,
  input  tkd_pkg::cfg_t    cfg,
  input  logic             mode_clear,
  output tkd_pkg::result_t result
);

  localparam logic [tkd_pkg::TIMER_W-1:0] TICK  = tkd_pkg::TIMER_W'(TICK_MS);
  localparam logic [tkd_pkg::COUNT_W-1:0] CLMAX = tkd_pkg::COUNT_W'(MAX_CLICKS);

  typedef struct packed {
    logic                        last_raw;
    logic                        stable;
    logic [tkd_pkg::TIMER_W-1:0] deb_timer;
    logic [tkd_pkg::TIMER_W-1:0] press_timer;
    logic                        long_done;
    logic                        hold_active;
    logic [tkd_pkg::TIMER_W-1:0] rep_timer;
  } key_t;

  typedef struct packed {
    key_t key;
    logic shot;
    logic rep;
  } calib_t;

  function automatic logic [tkd_pkg::TIMER_W-1:0] sat_add(
    input logic [tkd_pkg::TIMER_W-1:0] t
  );
    logic [tkd_pkg::TIMER_W:0] s;
    s = {1'b0, t} + {1'b0, TICK};
    return s[tkd_pkg::TIMER_W] ? {tkd_pkg::TIMER_W{1'b1}} : s[tkd_pkg::TIMER_W-1:0];
  endfunction

  function automatic key_t sample_key(input key_t k, input logic raw,
                                      input logic [tkd_pkg::TIMER_W-1:0] deb_time);
    key_t n;
    n = k;
    if (raw != k.last_raw) begin
      n.last_raw  = raw;
      n.deb_timer = '0;
    end else if (raw != k.stable) begin
      n.deb_timer = sat_add(k.deb_timer);
      if (n.deb_timer >= deb_time) begin
        if (!k.stable && raw) begin
          n.press_timer = '0;
          n.long_done   = 1'b0;
          n.hold_active = 1'b0;
          n.rep_timer   = '0;
        end
        n.stable = raw;
      end
    end else if (k.stable) begin
      n.press_timer = sat_add(k.press_timer);
      n.rep_timer   = sat_add(k.rep_timer);
    end
    return n;
  endfunction

  function automatic calib_t calib_events(input key_t k, input tkd_pkg::cfg_t c);
    calib_t r;
    r.key  = k;
    r.shot = 1'b0;
    r.rep  = 1'b0;
    if (k.stable) begin
      if (!r.key.hold_active && r.key.press_timer >= c.hold_start_time) begin
        r.key.hold_active = 1'b1;
        r.key.rep_timer   = '0;
      end
      if (r.key.hold_active && r.key.rep_timer >= c.repeat_period) begin
        r.key.rep_timer = '0;
        r.rep           = 1'b1;
      end
    end else if (k.press_timer != '0) begin
      if (!k.hold_active && k.press_timer < c.hold_start_time) r.shot = 1'b1;
      r.key.press_timer = '0;
    end
    return r;
  endfunction

  key_t                        power_key, mode_key;
  key_t                        power_key_next, mode_key_next;
  logic [tkd_pkg::COUNT_W-1:0] tap_counter, tap_counter_next;
  logic [tkd_pkg::TIMER_W-1:0] click_timer, click_timer_next;
  logic [tkd_pkg::TIMER_W-1:0] combo_timer, combo_timer_next;
  logic                        combo_done, combo_done_next;
  logic                        armed, armed_next;
  calib_t                      power_cal, mode_cal;

  always_comb begin
    power_key_next   = sample_key(power_key, power_raw, cfg.debounce_time);
    mode_key_next    = sample_key(mode_key, mode_raw, cfg.debounce_time);
    tap_counter_next = tap_counter;
    click_timer_next = click_timer;
    combo_timer_next = combo_timer;
    combo_done_next  = combo_done;
    armed_next       = armed;
    result           = '0;
    power_cal        = calib_events(power_key_next, cfg);
    mode_cal         = calib_events(mode_key_next, cfg);

    if (!armed) begin
      if (!power_key_next.stable) armed_next = 1'b1;
    end else if (cfg.cal_enable && power_key_next.stable && mode_key_next.stable) begin
      combo_timer_next = sat_add(combo_timer);
      if (!combo_done && combo_timer_next >= cfg.both_long_time) begin
        combo_done_next  = 1'b1;
        result.both_long = 1'b1;
      end
      power_key_next.press_timer = '0;
      mode_key_next.press_timer  = '0;
    end else begin
      combo_timer_next = '0;
      if (!power_key_next.stable && !mode_key_next.stable) combo_done_next = 1'b0;
      if (cfg.cal_enable) begin
        power_key_next      = power_cal.key;
        mode_key_next       = mode_cal.key;
        result.power_short  = power_cal.shot;
        result.power_repeat = power_cal.rep;
        result.mode_single  = mode_cal.shot;
        result.mode_repeat  = mode_cal.rep;
      end else begin
        if (power_key_next.stable) begin
          if (!power_key_next.long_done &&
              power_key_next.press_timer >= cfg.long_press_time) begin
            power_key_next.long_done = 1'b1;
            result.power_long        = 1'b1;
          end
        end else if (power_key_next.press_timer != '0) begin
          if (power_key_next.press_timer < cfg.long_press_time) result.power_short = 1'b1;
          power_key_next.press_timer = '0;
        end

        if (!mode_key_next.stable && mode_key_next.press_timer != '0) begin
          if (mode_key_next.press_timer < cfg.long_press_time &&
              tap_counter < CLMAX) begin
            tap_counter_next = tap_counter + 1'b1;
            click_timer_next = '0;
          end
          mode_key_next.press_timer = '0;
        end

        if (tap_counter_next != '0 && !mode_key_next.stable) begin
          click_timer_next = sat_add(click_timer_next);
          if (click_timer_next >= cfg.click_window) begin
            result.mode_clicks = 1'b1;
            result.click_total = tap_counter_next;
            tap_counter_next   = '0;
            click_timer_next   = '0;
          end
        end
      end
    end

    result.power_down = power_key_next.stable;
    result.mode_down  = mode_key_next.stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_key   <= '0;
      mode_key    <= '0;
      tap_counter <= '0;
      click_timer <= '0;
      combo_timer <= '0;
      combo_done  <= 1'b0;
      armed       <= 1'b0;
    end else if (mode_clear) begin
      tap_counter <= '0;
      click_timer <= '0;
      combo_timer <= '0;
      combo_done  <= 1'b0;
    end else if (step) begin
      power_key   <= power_key_next;
      mode_key    <= mode_key_next;
      tap_counter <= tap_counter_next;
      click_timer <= click_timer_next;
      combo_timer <= combo_timer_next;
      combo_done  <= combo_done_next;
      armed       <= armed_next;
    end
  end

endmodule

// ===== sv/two_key_debounce_click_long_press_top.sv =====
// ----------------------------------------------------------------------------
// Two-key debounce, click and long press scanner
// Takes one word of raw key levels per scan tick and returns one word of
// debounced levels and key events per tick.
// ----------------------------------------------------------------------------
// A word taken into the input register passes through the event core and its result
// word is registered in the result register once that register is free to accept it.
// Throughput: one word per cycle unless the result stalls; the input register, the event core update
// and the result register form a two-stage pipeline with a single state update.
// A stalled result holds the pipeline; the input side stalls only when full.
// Reset clears all key, click and combo state and loads the register defaults.
module two_key_debounce_click_long_press_top #(
  parameter int unsigned TICK_MS    = 10,
  parameter int unsigned MAX_CLICKS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 power_raw,
  input  logic                                 mode_raw,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 power_short,
  output logic                                 power_long,
  output logic                                 power_repeat,
  output logic                                 mode_single,
  output logic                                 mode_repeat,
  output logic                                 mode_clicks,
  output logic [tkd_pkg::COUNT_W-1:0]          click_total,
  output logic                                 both_long,
  output logic                                 power_down,
  output logic                                 mode_down,
  input  logic                                 cfg_write,
  input  logic [tkd_pkg::INDEX_W-1:0]          cfg_index,
  input  logic [tkd_pkg::TIMER_W-1:0]          cfg_data
);

  tkd_pkg::cfg_t    cfg;
  tkd_pkg::result_t core_result;
  tkd_pkg::result_t result_q;
  logic             mode_clear;
  logic             in_valid;
  logic             in_power;
  logic             in_mode;
  logic             step;

  assign step       = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !step;

  tkd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .mode_clear (mode_clear)
  );

  tkd_core #(
    .TICK_MS    (TICK_MS),
    .MAX_CLICKS (MAX_CLICKS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .power_raw  (in_power),
    .mode_raw   (in_mode),
    .cfg        (cfg),
    .mode_clear (mode_clear),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_power <= power_raw;
      in_mode  <= mode_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= core_result;
    end
  end

  assign power_short  = result_q.power_short;
  assign power_long   = result_q.power_long;
  assign power_repeat = result_q.power_repeat;
  assign mode_single  = result_q.mode_single;
  assign mode_repeat  = result_q.mode_repeat;
  assign mode_clicks  = result_q.mode_clicks;
  assign click_total  = result_q.click_total;
  assign both_long    = result_q.both_long;
  assign power_down   = result_q.power_down;
  assign mode_down    = result_q.mode_down;

endmodule

// ===== test/two_key_debounce_click_long_press_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key scanner testbench
// Drives scan ticks of raw key levels through the valid/stall handshake and
// checks every result word against a cycle-free predictor of the debounce,
// click, long press, auto-repeat and combo logic, or against a known word from
// the directed table. The directed table comes first, then random key sequences
// under several register settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module two_key_debounce_click_long_press_top_tb;

  localparam int unsigned TICK_MS     = 10;
  localparam int unsigned MAX_CLICKS  = 10;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned NUM_PHASES  = 13;
  localparam int unsigned PHASE_SCANS = 40;
  localparam int unsigned LONG_HOLD   = 200;
  localparam logic [tkd_pkg::INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ROW_TICK, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [tkd_pkg::INDEX_W-1:0] index;
    logic [tkd_pkg::TIMER_W-1:0] data;
    logic                        power;
    logic                        mode;
    tkd_pkg::result_t            want;
  } row_t;

  localparam int NUM_ROWS = 35;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_KNOWN, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_DEBOUNCE_TIME, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_REG, tkd_pkg::REG_DEBOUNCE_TIME, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_LONG_PRESS_TIME, 16'd20, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_CLICK_WINDOW, 16'd10, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_CAL_ENABLE, 16'd1, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_HOLD_START_TIME, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_REPEAT_PERIOD, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REG, tkd_pkg::REG_BOTH_LONG_TIME, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_UNUSED, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b1, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b1, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic                        power_raw = 1'b0;
  logic                        mode_raw = 1'b0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic                        power_short;
  logic                        power_long;
  logic                        power_repeat;
  logic                        mode_single;
  logic                        mode_repeat;
  logic                        mode_clicks;
  logic [tkd_pkg::COUNT_W-1:0] click_total;
  logic                        both_long;
  logic                        power_down;
  logic                        mode_down;
  logic                        cfg_write = 1'b0;
  logic [tkd_pkg::INDEX_W-1:0] cfg_index = '0;
  logic [tkd_pkg::TIMER_W-1:0] cfg_data = '0;

  tkd_pkg::result_t out_word;
  tkd_pkg::result_t pending_events [$];
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      scans_sent = 0;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      hold_left = 0;
  logic             hold_req = 1'b0;
  logic             hold_done = 1'b0;

  tkd_pkg::cfg_t               model_cfg;
  logic                        raw_seen [2];
  logic                        level [2];
  logic                        long_seen [2];
  logic                        repeating [2];
  logic [tkd_pkg::TIMER_W-1:0] settle_t [2];
  logic [tkd_pkg::TIMER_W-1:0] held_t [2];
  logic [tkd_pkg::TIMER_W-1:0] repeat_t [2];
  logic [tkd_pkg::COUNT_W-1:0] tap_count;
  logic [tkd_pkg::TIMER_W-1:0] quiet_t;
  logic [tkd_pkg::TIMER_W-1:0] both_t;
  logic                        both_seen;
  logic                        armed;

  two_key_debounce_click_long_press_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .power_raw    (power_raw),
    .mode_raw     (mode_raw),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .power_short  (power_short),
    .power_long   (power_long),
    .power_repeat (power_repeat),
    .mode_single  (mode_single),
    .mode_repeat  (mode_repeat),
    .mode_clicks  (mode_clicks),
    .click_total  (click_total),
    .both_long    (both_long),
    .power_down   (power_down),
    .mode_down    (mode_down),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  assign out_word = {power_short, power_long, power_repeat, mode_single, mode_repeat,
                     mode_clicks, click_total, both_long, power_down, mode_down};

  always #5 clk = ~clk;

  function automatic logic [tkd_pkg::TIMER_W-1:0] tick_add(
    input logic [tkd_pkg::TIMER_W-1:0] t
  );
    logic [tkd_pkg::TIMER_W:0] s;
    s = {1'b0, t} + (tkd_pkg::TIMER_W+1)'(TICK_MS);
    return s[tkd_pkg::TIMER_W] ? {tkd_pkg::TIMER_W{1'b1}} : s[tkd_pkg::TIMER_W-1:0];
  endfunction

  function automatic void sample_key(input int k, input logic raw);
    if (raw != raw_seen[k]) begin
      raw_seen[k] = raw;
      settle_t[k] = '0;
    end else if (raw != level[k]) begin
      settle_t[k] = tick_add(settle_t[k]);
      if (settle_t[k] >= model_cfg.debounce_time) begin
        if (!level[k] && raw) begin
          held_t[k] = '0;
          long_seen[k] = 1'b0;
          repeating[k] = 1'b0;
          repeat_t[k] = '0;
        end
        level[k] = raw;
      end
    end else if (level[k]) begin
      held_t[k] = tick_add(held_t[k]);
      repeat_t[k] = tick_add(repeat_t[k]);
    end
  endfunction

  function automatic void calib_key(input int k, output logic shot, output logic rep);
    shot = 1'b0;
    rep = 1'b0;
    if (level[k]) begin
      if (!repeating[k] && held_t[k] >= model_cfg.hold_start_time) begin
        repeating[k] = 1'b1;
        repeat_t[k] = '0;
      end
      if (repeating[k] && repeat_t[k] >= model_cfg.repeat_period) begin
        repeat_t[k] = '0;
        rep = 1'b1;
      end
    end else if (held_t[k] != '0) begin
      if (!repeating[k] && held_t[k] < model_cfg.hold_start_time) begin
        shot = 1'b1;
      end
      held_t[k] = '0;
    end
  endfunction

  function automatic tkd_pkg::result_t predict_scan(input logic p, input logic m);
    tkd_pkg::result_t r;
    logic             shot;
    logic             rep;
    r = '0;
    sample_key(0, p);
    sample_key(1, m);
    if (!armed) begin
      if (!level[0]) armed = 1'b1;
    end else if (model_cfg.cal_enable && level[0] && level[1]) begin
      both_t = tick_add(both_t);
      if (!both_seen && both_t >= model_cfg.both_long_time) begin
        both_seen = 1'b1;
        r.both_long = 1'b1;
      end
      held_t[0] = '0;
      held_t[1] = '0;
    end else begin
      both_t = '0;
      if (!level[0] && !level[1]) both_seen = 1'b0;
      if (model_cfg.cal_enable) begin
        calib_key(0, shot, rep);
        r.power_short = shot;
        r.power_repeat = rep;
        calib_key(1, shot, rep);
        r.mode_single = shot;
        r.mode_repeat = rep;
      end else begin
        if (level[0]) begin
          if (!long_seen[0] && held_t[0] >= model_cfg.long_press_time) begin
            long_seen[0] = 1'b1;
            r.power_long = 1'b1;
          end
        end else if (held_t[0] != '0) begin
          if (held_t[0] < model_cfg.long_press_time) r.power_short = 1'b1;
          held_t[0] = '0;
        end
        if (!level[1] && held_t[1] != '0) begin
          if (held_t[1] < model_cfg.long_press_time &&
              tap_count < tkd_pkg::COUNT_W'(MAX_CLICKS)) begin
            tap_count = tap_count + 1'b1;
            quiet_t = '0;
          end
          held_t[1] = '0;
        end
        if (tap_count != '0 && !level[1]) begin
          quiet_t = tick_add(quiet_t);
          if (quiet_t >= model_cfg.click_window) begin
            r.mode_clicks = 1'b1;
            r.click_total = tap_count;
            tap_count = '0;
            quiet_t = '0;
          end
        end
      end
    end
    r.power_down = level[0];
    r.mode_down = level[1];
    return r;
  endfunction

  function automatic void load_reg(input logic [tkd_pkg::INDEX_W-1:0] idx,
                                   input logic [tkd_pkg::TIMER_W-1:0] d);
    case (idx)
      tkd_pkg::REG_CAL_ENABLE: begin
        model_cfg.cal_enable = d[0];
        tap_count = '0;
        quiet_t = '0;
        both_t = '0;
        both_seen = 1'b0;
      end
      tkd_pkg::REG_DEBOUNCE_TIME:   model_cfg.debounce_time = d;
      tkd_pkg::REG_LONG_PRESS_TIME: model_cfg.long_press_time = d;
      tkd_pkg::REG_REPEAT_PERIOD:   model_cfg.repeat_period = d;
      tkd_pkg::REG_BOTH_LONG_TIME:  model_cfg.both_long_time = d;
      tkd_pkg::REG_CLICK_WINDOW:    model_cfg.click_window = d;
      tkd_pkg::REG_HOLD_START_TIME: model_cfg.hold_start_time = d;
      default: ;
    endcase
  endfunction

  function automatic logic [tkd_pkg::TIMER_W-1:0] spice(
    input logic [tkd_pkg::TIMER_W-1:0] v
  );
    if ($urandom_range(9) != 0) return v;
    return ($urandom_range(1) != 0) ? {tkd_pkg::TIMER_W{1'b1}} : '0;
  endfunction

  task automatic report(input string msg);
    error_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_word(input tkd_pkg::result_t got);
    tkd_pkg::result_t want;
    if (pending_events.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    want = pending_events.pop_front();
    if (got.power_short != want.power_short)
      report($sformatf("power_short %0d, expected %0d", got.power_short, want.power_short));
    if (got.power_long != want.power_long)
      report($sformatf("power_long %0d, expected %0d", got.power_long, want.power_long));
    if (got.power_repeat != want.power_repeat)
      report($sformatf("power_repeat %0d, expected %0d", got.power_repeat, want.power_repeat));
    if (got.mode_single != want.mode_single)
      report($sformatf("mode_single %0d, expected %0d", got.mode_single, want.mode_single));
    if (got.mode_repeat != want.mode_repeat)
      report($sformatf("mode_repeat %0d, expected %0d", got.mode_repeat, want.mode_repeat));
    if (got.mode_clicks != want.mode_clicks)
      report($sformatf("mode_clicks %0d, expected %0d", got.mode_clicks, want.mode_clicks));
    if (got.click_total != want.click_total)
      report($sformatf("click_total %0d, expected %0d", got.click_total, want.click_total));
    if (got.both_long != want.both_long)
      report($sformatf("both_long %0d, expected %0d", got.both_long, want.both_long));
    if (got.power_down != want.power_down)
      report($sformatf("power_down %0d, expected %0d", got.power_down, want.power_down));
    if (got.mode_down != want.mode_down)
      report($sformatf("mode_down %0d, expected %0d", got.mode_down, want.mode_down));
  endtask

  task automatic send_scan(input logic p, input logic m);
    cfg_write <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    power_raw <= p;
    mode_raw <= m;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_events.push_back(predict_scan(p, m));
    scans_sent++;
  endtask

  task automatic write_reg(input logic [tkd_pkg::INDEX_W-1:0] idx,
                           input logic [tkd_pkg::TIMER_W-1:0] d);
    item_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    load_reg(idx, d);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_word(out_word);
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic                        p;
    logic                        m;
    logic                        drained;
    logic                        cal;
    logic [tkd_pkg::TIMER_W-1:0] deb, lng, rpt, both_ms, win, hold_ms;
    int unsigned                 phase_end;
    int unsigned                 pick;
    int unsigned                 len;
    int unsigned                 taps;

    model_cfg = '{cal_enable: 1'b0,
                  debounce_time: tkd_pkg::RST_DEBOUNCE_TIME,
                  long_press_time: tkd_pkg::RST_LONG_PRESS_TIME,
                  repeat_period: tkd_pkg::RST_REPEAT_PERIOD,
                  both_long_time: tkd_pkg::RST_BOTH_LONG_TIME,
                  click_window: tkd_pkg::RST_CLICK_WINDOW,
                  hold_start_time: tkd_pkg::RST_HOLD_START_TIME};
    for (int k = 0; k < 2; k++) begin
      raw_seen[k] = 1'b0;
      level[k] = 1'b0;
      long_seen[k] = 1'b0;
      repeating[k] = 1'b0;
      settle_t[k] = '0;
      held_t[k] = '0;
      repeat_t[k] = '0;
    end
    tap_count = '0;
    quiet_t = '0;
    both_t = '0;
    both_seen = 1'b0;
    armed = 1'b0;
    drained = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      case (DIRECTED[i].kind)
        ROW_REG: write_reg(DIRECTED[i].index, DIRECTED[i].data);
        ROW_KNOWN: begin
          send_scan(DIRECTED[i].power, DIRECTED[i].mode);
          pending_events[pending_events.size()-1] = DIRECTED[i].want;
        end
        default: send_scan(DIRECTED[i].power, DIRECTED[i].mode);
      endcase
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 57; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 57; end
        default: begin idle_pct = 19; stall_pct <= 19; end
      endcase
      cal = 1'($urandom_range(1));
      deb = 16'(TICK_MS * $urandom_range(0, 4));
      lng = spice(16'(TICK_MS * $urandom_range(2, 40)));
      rpt = spice(16'(TICK_MS * $urandom_range(0, 10)));
      both_ms = spice(16'(TICK_MS * $urandom_range(0, 30)));
      win = spice(16'(TICK_MS * $urandom_range(1, 30)));
      hold_ms = spice(16'(TICK_MS * $urandom_range(0, 20)));
      if (phase == 0) begin
        deb = '0;
        lng = '0;
        rpt = '0;
        both_ms = '0;
        win = '0;
        hold_ms = '0;
      end else if (phase == 1) begin
        deb = '0;
        lng = '1;
        rpt = '1;
        both_ms = '1;
        win = '1;
        hold_ms = '1;
      end
      write_reg(tkd_pkg::REG_CAL_ENABLE, {15'd0, cal});
      write_reg(tkd_pkg::REG_DEBOUNCE_TIME, deb);
      write_reg(tkd_pkg::REG_LONG_PRESS_TIME, lng);
      write_reg(tkd_pkg::REG_REPEAT_PERIOD, rpt);
      write_reg(tkd_pkg::REG_BOTH_LONG_TIME, both_ms);
      write_reg(tkd_pkg::REG_CLICK_WINDOW, win);
      write_reg(tkd_pkg::REG_HOLD_START_TIME, hold_ms);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      if (phase == 4) hold_req <= 1'b1;

      phase_end = scans_sent + PHASE_SCANS;
      while (scans_sent < phase_end) begin
        if (phase == 6 && !drained && phase_end - scans_sent < 30) begin
          item_valid <= 1'b0;
          while (pending_events.size() != 0) @(posedge clk);
          drained = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 20) begin
          // A burst of eight to thirteen mode taps, which can run past the click limit.
          p = ($urandom_range(3) == 0);
          taps = $urandom_range(8, 13);
          repeat (taps) begin
            len = $urandom_range(2, 5);
            repeat (len) send_scan(p, 1'b1);
            len = $urandom_range(2, 4);
            repeat (len) send_scan(p, 1'b0);
          end
        end else if (pick < 30) begin
          len = $urandom_range(2, 6);
          repeat (len) send_scan(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          p = 1'($urandom_range(1));
          m = 1'($urandom_range(1));
          len = ($urandom_range(4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
          repeat (len) send_scan(p, m);
        end
      end
    end

    idle_pct = 0;
    stall_pct <= 0;
    item_valid <= 1'b0;
    cfg_write <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== two_key_debounce_click_long_press_top.f =====
sv/tkd_pkg.sv
sv/tkd_cfg.sv
sv/tkd_core.sv
sv/two_key_debounce_click_long_press_top.sv
test/two_key_debounce_click_long_press_top_tb.sv
